@@ rtl/fsgs_pkg.sv @@
package fsgs_pkg;

   // Item kinds carried on req_tuser
   typedef enum logic [1:0] {
      ACT_WRITE   = 2'd0,
      ACT_READ    = 2'd1,
      ACT_ADVANCE = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   // Configuration register indexes
   localparam logic [1:0] REG_ACTIVE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_ACTIVE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_EMPTY_VALUE   = 2'd2;
   localparam logic [1:0] REG_SAND_VALUE    = 2'd3;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 9;
   localparam int SIZE_BITS      = 9;
   localparam int VALUE_BITS     = 8;

   localparam logic [SIZE_BITS-1:0]  ACTIVE_SIZE_RESET = 9'd256;
   localparam logic [VALUE_BITS-1:0] EMPTY_RESET       = 8'd0;
   localparam logic [VALUE_BITS-1:0] SAND_RESET        = 8'd1;

   // Grid memory address source
   typedef enum logic [2:0] {
      ADDR_REQ    = 3'd0,
      ADDR_HERE   = 3'd1,
      ADDR_BELOW  = 3'd2,
      ADDR_BL     = 3'd3,
      ADDR_BR     = 3'd4,
      ADDR_TARGET = 3'd5,
      ADDR_CLEAR  = 3'd6
   } addr_sel_type;

   // Grid memory write data source
   typedef enum logic [1:0] {
      WD_REQ   = 2'd0,
      WD_SAND  = 2'd1,
      WD_EMPTY = 2'd2,
      WD_ZERO  = 2'd3
   } wdata_sel_type;

   // Which neighbor below receives the sand
   typedef enum logic [1:0] {
      TGT_BELOW = 2'd0,
      TGT_BL    = 2'd1,
      TGT_BR    = 2'd2
   } tgt_sel_type;

   typedef struct packed {
      logic          req_load;
      addr_sel_type  addr_sel;
      logic          mem_we;
      logic          mem_re;
      wdata_sel_type wdata_sel;
      logic          clr_step;
      logic          frame_init;
      logic          frame_step;
      logic          tgt_load;
      tgt_sel_type   tgt_sel;
      logic          rsp_load;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       in_area;
      logic       frame_none;
      logic       rd_is_sand;
      logic       rd_is_empty;
      logic       col_gt0;
      logic       has_right;
      logic       last_col;
      logic       last_row;
      logic       clr_last;
      logic       rsp_free;
   } status_type;

endpackage

@@ rtl/falling_sand_grid_step_unit.sv @@
// Falling-sand grid engine. The grid (GRID_WIDTH x GRID_HEIGHT cells of CELL_BITS bits) sits
// in one single-port memory, so accesses are made one at a time and the timing follows from
// the count of accesses. After reset the block sweeps zeros through the whole memory, one
// cell a cycle, with req_tready low; csr writes are taken at any time.
// A write or a read item passes through a decode state, which makes its memory access, and a
// response state, which loads the result into the output register once that is free; the
// next item is accepted after that. An advance scans the active area from row 1 upward, left
// to right, unless the area has fewer than two rows or no column: a non-sand cell costs one
// read, a sand cell adds up to three neighbor reads, and two writes when it moves; after the
// last cell the result passes through the response state as well.
// One item is in flight at a time; the finished result waits in an output register, and the
// next item is accepted while it waits.
module falling_sand_grid_step_unit #(
   parameter int GRID_WIDTH  = 256,
   parameter int GRID_HEIGHT = 256,
   parameter int CELL_BITS   = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [fsgs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [fsgs_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [23:0]                           req_tdata,  // col, row, cell_value
   input  logic [1:0]                            req_tuser,  // action
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [7:0]                            rsp_tdata,  // read_value
   output logic                                  rsp_tuser   // frame_done
);

   fsgs_pkg::cmd_type    cmd;
   fsgs_pkg::status_type status;

   fsgs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fsgs_dp #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT),
      .CELL_BITS   (CELL_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

@@ rtl/fsgs_ctrl.sv @@
module fsgs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  fsgs_pkg::status_type  status,
   output fsgs_pkg::cmd_type     cmd
);

   typedef enum logic [11:0] {
      S_CLEAR      = 12'b000000000001,
      S_IDLE       = 12'b000000000010,
      S_DECODE     = 12'b000000000100,
      S_F_HERE     = 12'b000000001000,
      S_F_CHK_HERE = 12'b000000010000,
      S_F_CHK_B    = 12'b000000100000,
      S_F_CHK_L    = 12'b000001000000,
      S_F_CHK_R    = 12'b000010000000,
      S_F_WR_T     = 12'b000100000000,
      S_F_WR_H     = 12'b001000000000,
      S_F_NEXT     = 12'b010000000000,
      S_RESP       = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.addr_sel  = fsgs_pkg::ADDR_CLEAR;
            cmd.wdata_sel = fsgs_pkg::WD_ZERO;
            cmd.mem_we    = 1'b1;
            cmd.clr_step  = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.req_load = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_RESP;
            unique case (status.action)
               fsgs_pkg::ACT_WRITE: begin
                  cmd.addr_sel  = fsgs_pkg::ADDR_REQ;
                  cmd.wdata_sel = fsgs_pkg::WD_REQ;
                  cmd.mem_we    = status.in_area;
               end
               fsgs_pkg::ACT_READ: begin
                  cmd.addr_sel = fsgs_pkg::ADDR_REQ;
                  cmd.mem_re   = status.in_area;
               end
               fsgs_pkg::ACT_ADVANCE: begin
                  if (!status.frame_none) begin
                     cmd.frame_init = 1'b1;
                     state_in       = S_F_HERE;
                  end
               end
               fsgs_pkg::ACT_NONE: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_F_HERE: begin
            cmd.addr_sel = fsgs_pkg::ADDR_HERE;
            cmd.mem_re   = 1'b1;
            state_in     = S_F_CHK_HERE;
         end
         S_F_CHK_HERE: begin
            if (status.rd_is_sand) begin
               cmd.addr_sel = fsgs_pkg::ADDR_BELOW;
               cmd.mem_re   = 1'b1;
               state_in     = S_F_CHK_B;
            end else begin
               state_in = S_F_NEXT;
            end
         end
         S_F_CHK_B: begin
            priority if (status.rd_is_empty) begin
               cmd.tgt_load = 1'b1;
               cmd.tgt_sel  = fsgs_pkg::TGT_BELOW;
               state_in     = S_F_WR_T;
            end else if (status.col_gt0) begin
               cmd.addr_sel = fsgs_pkg::ADDR_BL;
               cmd.mem_re   = 1'b1;
               state_in     = S_F_CHK_L;
            end else if (status.has_right) begin
               cmd.addr_sel = fsgs_pkg::ADDR_BR;
               cmd.mem_re   = 1'b1;
               state_in     = S_F_CHK_R;
            end else begin
               state_in = S_F_NEXT;
            end
         end
         S_F_CHK_L: begin
            priority if (status.rd_is_empty) begin
               cmd.tgt_load = 1'b1;
               cmd.tgt_sel  = fsgs_pkg::TGT_BL;
               state_in     = S_F_WR_T;
            end else if (status.has_right) begin
               cmd.addr_sel = fsgs_pkg::ADDR_BR;
               cmd.mem_re   = 1'b1;
               state_in     = S_F_CHK_R;
            end else begin
               state_in = S_F_NEXT;
            end
         end
         S_F_CHK_R: begin
            if (status.rd_is_empty) begin
               cmd.tgt_load = 1'b1;
               cmd.tgt_sel  = fsgs_pkg::TGT_BR;
               state_in     = S_F_WR_T;
            end else begin
               state_in = S_F_NEXT;
            end
         end
         S_F_WR_T: begin
            cmd.addr_sel  = fsgs_pkg::ADDR_TARGET;
            cmd.wdata_sel = fsgs_pkg::WD_SAND;
            cmd.mem_we    = 1'b1;
            state_in      = S_F_WR_H;
         end
         S_F_WR_H: begin
            cmd.addr_sel  = fsgs_pkg::ADDR_HERE;
            cmd.wdata_sel = fsgs_pkg::WD_EMPTY;
            cmd.mem_we    = 1'b1;
            state_in      = S_F_NEXT;
         end
         S_F_NEXT: begin
            cmd.frame_step = 1'b1;
            if (status.last_col && status.last_row) begin
               state_in = S_RESP;
            end else begin
               state_in = S_F_HERE;
            end
         end
         S_RESP: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

@@ rtl/fsgs_dp.sv @@
module fsgs_dp #(
   parameter int GRID_WIDTH  = 256,
   parameter int GRID_HEIGHT = 256,
   parameter int CELL_BITS   = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [fsgs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [fsgs_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  logic [23:0]                           req_tdata,
   input  logic [1:0]                            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [7:0]                            rsp_tdata,
   output logic                                  rsp_tuser,
   input  fsgs_pkg::cmd_type                     cmd,
   output fsgs_pkg::status_type                  status
);

   localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int CBW   = $clog2(GRID_WIDTH);
   localparam int RBW   = $clog2(GRID_HEIGHT);
   localparam int EWW   = ($clog2(GRID_WIDTH + 1) > 9) ? $clog2(GRID_WIDTH + 1) : 9;
   localparam int EHW   = ($clog2(GRID_HEIGHT + 1) > 9) ? $clog2(GRID_HEIGHT + 1) : 9;
   localparam int XW    = CELL_BITS + 8;

   // Configuration registers
   logic [fsgs_pkg::SIZE_BITS-1:0]  act_w_ff, act_h_ff;
   logic [fsgs_pkg::VALUE_BITS-1:0] empty_ff, sand_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_w_ff <= fsgs_pkg::ACTIVE_SIZE_RESET;
         act_h_ff <= fsgs_pkg::ACTIVE_SIZE_RESET;
         empty_ff <= fsgs_pkg::EMPTY_RESET;
         sand_ff  <= fsgs_pkg::SAND_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            fsgs_pkg::REG_ACTIVE_WIDTH:  act_w_ff <= csr_wdata;
            fsgs_pkg::REG_ACTIVE_HEIGHT: act_h_ff <= csr_wdata;
            fsgs_pkg::REG_EMPTY_VALUE:   empty_ff <= csr_wdata[7:0];
            fsgs_pkg::REG_SAND_VALUE:    sand_ff  <= csr_wdata[7:0];
         endcase
      end
   end

   // Active size clamped to the grid
   logic [EWW-1:0] eff_w;
   logic [EHW-1:0] eff_h;

   assign eff_w = (EWW'(act_w_ff) < EWW'(GRID_WIDTH)) ? EWW'(act_w_ff) : EWW'(GRID_WIDTH);
   assign eff_h = (EHW'(act_h_ff) < EHW'(GRID_HEIGHT)) ? EHW'(act_h_ff) : EHW'(GRID_HEIGHT);

   // Empty and sand codes at cell width
   logic [XW-1:0]        emp_x, snd_x, emp_cell_x;
   logic [CELL_BITS-1:0] emp_cell, snd_cell;

   assign emp_x      = XW'(empty_ff);
   assign snd_x      = XW'(sand_ff);
   assign emp_cell   = emp_x[CELL_BITS-1:0];
   assign snd_cell   = snd_x[CELL_BITS-1:0];
   assign emp_cell_x = XW'(emp_cell);

   // Latched request
   fsgs_pkg::action_type req_action_ff;
   logic [7:0]           req_col_ff, req_row_ff, req_value_ff;

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         req_action_ff <= fsgs_pkg::action_type'(req_tuser);
         req_col_ff    <= req_tdata[7:0];
         req_row_ff    <= req_tdata[15:8];
         req_value_ff  <= req_tdata[23:16];
      end
   end

   logic                 in_area;
   logic [AW-1:0]        req_addr;
   logic [XW-1:0]        req_value_x;
   logic [CELL_BITS-1:0] req_cell;

   assign in_area     = (EWW'(req_col_ff) < eff_w) && (EHW'(req_row_ff) < eff_h);
   assign req_addr    = AW'(32'(req_row_ff) * 32'(GRID_WIDTH) + 32'(req_col_ff));
   assign req_value_x = XW'(req_value_ff);
   assign req_cell    = req_value_x[CELL_BITS-1:0];

   // Frame scan position: column, row and the base addresses of this row and the one below
   logic [CBW-1:0] col_ff, col_in;
   logic [RBW-1:0] row_ff, row_in;
   logic [AW-1:0]  row_base_ff, row_base_in;
   logic [AW-1:0]  below_base_ff, below_base_in;
   logic [EWW-1:0] col_next;
   logic           last_col;

   assign col_next = EWW'(col_ff) + EWW'(1);
   assign last_col = (col_next == eff_w);

   always_comb begin
      col_in        = col_ff;
      row_in        = row_ff;
      row_base_in   = row_base_ff;
      below_base_in = below_base_ff;
      priority if (cmd.frame_init) begin
         col_in        = '0;
         row_in        = RBW'(1);
         row_base_in   = AW'(GRID_WIDTH);
         below_base_in = '0;
      end else if (cmd.frame_step) begin
         if (last_col) begin
            col_in        = '0;
            row_in        = row_ff + RBW'(1);
            row_base_in   = row_base_ff + AW'(GRID_WIDTH);
            below_base_in = below_base_ff + AW'(GRID_WIDTH);
         end else begin
            col_in = col_ff + CBW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      col_ff        <= col_in;
      row_ff        <= row_in;
      row_base_ff   <= row_base_in;
      below_base_ff <= below_base_in;
   end

   logic [AW-1:0] here_addr, below_addr, bl_addr, br_addr, tgt_addr;

   assign here_addr  = row_base_ff + AW'(col_ff);
   assign below_addr = below_base_ff + AW'(col_ff);
   assign bl_addr    = below_addr - AW'(1);
   assign br_addr    = below_addr + AW'(1);

   // Chosen landing cell for a moving grain
   fsgs_pkg::tgt_sel_type tgt_ff;

   always_ff @(posedge clock) begin
      if (cmd.tgt_load) begin
         tgt_ff <= cmd.tgt_sel;
      end
   end

   always_comb begin
      unique case (tgt_ff)
         fsgs_pkg::TGT_BELOW: tgt_addr = below_addr;
         fsgs_pkg::TGT_BL:    tgt_addr = bl_addr;
         fsgs_pkg::TGT_BR:    tgt_addr = br_addr;
         default:             tgt_addr = below_addr;
      endcase
   end

   // Clearing sweep after reset
   logic [AW-1:0] clr_ff, clr_in;

   assign clr_in = cmd.clr_step ? clr_ff + AW'(1) : clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   // Grid memory port
   logic [AW-1:0]        mem_addr;
   logic [CELL_BITS-1:0] mem_wdata;
   logic [CELL_BITS-1:0] rd_ff;
   logic [CELL_BITS-1:0] grid_mem [DEPTH];

   always_comb begin
      unique case (cmd.addr_sel)
         fsgs_pkg::ADDR_REQ:    mem_addr = req_addr;
         fsgs_pkg::ADDR_HERE:   mem_addr = here_addr;
         fsgs_pkg::ADDR_BELOW:  mem_addr = below_addr;
         fsgs_pkg::ADDR_BL:     mem_addr = bl_addr;
         fsgs_pkg::ADDR_BR:     mem_addr = br_addr;
         fsgs_pkg::ADDR_TARGET: mem_addr = tgt_addr;
         fsgs_pkg::ADDR_CLEAR:  mem_addr = clr_ff;
         default:               mem_addr = clr_ff;
      endcase
   end

   always_comb begin
      unique case (cmd.wdata_sel)
         fsgs_pkg::WD_REQ:   mem_wdata = req_cell;
         fsgs_pkg::WD_SAND:  mem_wdata = snd_cell;
         fsgs_pkg::WD_EMPTY: mem_wdata = emp_cell;
         fsgs_pkg::WD_ZERO:  mem_wdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         grid_mem[mem_addr] <= mem_wdata;
      end
      if (cmd.mem_re) begin
         rd_ff <= grid_mem[mem_addr];
      end
   end

   // Result slot
   logic          rsp_valid_ff;
   logic [7:0]    rsp_data_ff;
   logic          rsp_done_ff;
   logic [XW-1:0] rd_x;
   logic [7:0]    rsp_data_in;

   assign rd_x = XW'(rd_ff);

   // Outside the active area a read returns the empty code at cell width
   always_comb begin
      rsp_data_in = '0;
      if (req_action_ff == fsgs_pkg::ACT_READ) begin
         rsp_data_in = in_area ? rd_x[7:0] : emp_cell_x[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_done_ff <= (req_action_ff == fsgs_pkg::ACT_ADVANCE);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_done_ff;

   // Status to the controller
   assign status.action      = req_action_ff;
   assign status.in_area     = in_area;
   assign status.frame_none  = (eff_h <= EHW'(1)) || (eff_w == '0);
   assign status.rd_is_sand  = (rd_ff == snd_cell);
   assign status.rd_is_empty = (rd_ff == emp_cell);
   assign status.col_gt0     = (col_ff != '0);
   assign status.has_right   = (col_next < eff_w);
   assign status.last_col    = last_col;
   assign status.last_row    = ((EHW'(row_ff) + EHW'(1)) == eff_h);
   assign status.clr_last    = (clr_ff == AW'(DEPTH - 1));
   assign status.rsp_free    = !rsp_valid_ff || rsp_tready;

endmodule

@@ verif/falling_sand_grid_step_unit_tb.sv @@
`timescale 1ns / 1ps

module falling_sand_grid_step_unit_tb;

   localparam int GRID_SIDE   = 256;
   localparam int HOLD_CYCLES = 200;

   typedef struct {
      logic [7:0] read_value;
      logic       frame_done;
   } cell_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [fsgs_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [fsgs_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // col, row, cell_value
   logic [1:0]  req_tuser = '0;   // action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // read_value
   logic        rsp_tuser;        // frame_done

   // Shadow copy of the grid and the registers
   logic [7:0] shadow_grid [0:GRID_SIDE*GRID_SIDE-1];
   logic [8:0] shadow_width  = fsgs_pkg::ACTIVE_SIZE_RESET;
   logic [8:0] shadow_height = fsgs_pkg::ACTIVE_SIZE_RESET;
   logic [7:0] shadow_empty  = fsgs_pkg::EMPTY_RESET;
   logic [7:0] shadow_sand   = fsgs_pkg::SAND_RESET;

   cell_result_type expected_cells[$];
   int  mismatch_count = 0;
   bit  hold_toggle = 1'b0;
   bit  hold_seen = 1'b0;
   int  hold_left = 0;
   bit  no_idle = 1'b0;

   falling_sand_grid_step_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- shadow model
   function automatic int active_cols();
      return (shadow_width < GRID_SIDE) ? int'(shadow_width) : GRID_SIDE;
   endfunction

   function automatic int active_rows();
      return (shadow_height < GRID_SIDE) ? int'(shadow_height) : GRID_SIDE;
   endfunction

   // One frame, bottom row up, left to right, in place
   function automatic void advance_shadow_grid();
      int w;
      int h;
      int here;
      int below;
      w = active_cols();
      h = active_rows();
      for (int r = 1; r < h; r++) begin
         for (int c = 0; c < w; c++) begin
            here  = r * GRID_SIDE + c;
            below = here - GRID_SIDE;
            if (shadow_grid[here] != shadow_sand)
               continue;
            if (shadow_grid[below] == shadow_empty) begin
               shadow_grid[below] = shadow_sand;
               shadow_grid[here]  = shadow_empty;
            end else if (c > 0 && shadow_grid[below-1] == shadow_empty) begin
               shadow_grid[below-1] = shadow_sand;
               shadow_grid[here]    = shadow_empty;
            end else if (c + 1 < w && shadow_grid[below+1] == shadow_empty) begin
               shadow_grid[below+1] = shadow_sand;
               shadow_grid[here]    = shadow_empty;
            end
         end
      end
   endfunction

   function automatic cell_result_type apply_cell_item(fsgs_pkg::action_type act,
                                                       logic [7:0] c, logic [7:0] r,
                                                       logic [7:0] v);
      cell_result_type res;
      bit              in_area;
      res.read_value = 8'd0;
      res.frame_done = 1'b0;
      in_area = (int'(c) < active_cols()) && (int'(r) < active_rows());
      case (act)
         fsgs_pkg::ACT_WRITE: begin
            if (in_area)
               shadow_grid[{r, c}] = v;
         end
         fsgs_pkg::ACT_READ: begin
            res.read_value = in_area ? shadow_grid[{r, c}] : shadow_empty;
         end
         fsgs_pkg::ACT_ADVANCE: begin
            advance_shadow_grid();
            res.frame_done = 1'b1;
         end
         default: ;
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------- driving
   task automatic send_cell_item(fsgs_pkg::action_type act, logic [7:0] c, logic [7:0] r,
                                 logic [7:0] v);
      while (!no_idle && $urandom_range(99) < 23) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {v, r, c};
      req_tuser  <= act;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      // valid stays up; the next call or the drain decides in this same step
      expected_cells.push_back(apply_cell_item(act, c, r, v));
   endtask

   task automatic write_cell(logic [7:0] c, logic [7:0] r, logic [7:0] v);
      send_cell_item(fsgs_pkg::ACT_WRITE, c, r, v);
   endtask

   task automatic read_cell(logic [7:0] c, logic [7:0] r);
      send_cell_item(fsgs_pkg::ACT_READ, c, r, 8'($urandom_range(0, 255)));
   endtask

   task automatic advance_frame();
      send_cell_item(fsgs_pkg::ACT_ADVANCE, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
   endtask

   // Sender pauses until every outstanding result is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_cells.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Called only with the block idle, at a rising edge
   task automatic write_reg(logic [fsgs_pkg::CSR_INDEX_BITS-1:0] idx,
                            logic [fsgs_pkg::CSR_DATA_BITS-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      case (idx)
         fsgs_pkg::REG_ACTIVE_WIDTH:  shadow_width  = val;
         fsgs_pkg::REG_ACTIVE_HEIGHT: shadow_height = val;
         fsgs_pkg::REG_EMPTY_VALUE:   shadow_empty  = val[7:0];
         fsgs_pkg::REG_SAND_VALUE:    shadow_sand   = val[7:0];
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------- result side
   // A toggle of hold_toggle starts a long hold-off, counted here
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen = hold_toggle;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(99) >= 23);
      end
   end

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_results
      cell_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_cells.size() == 0) begin
            report_mismatch("item with nothing pending", rsp_tdata, 8'd0);
         end else begin
            want = expected_cells.pop_front();
            if (rsp_tdata !== want.read_value)
               report_mismatch("read_value", rsp_tdata, want.read_value);
            if (rsp_tuser !== want.frame_done)
               report_mismatch("frame_done", {7'd0, rsp_tuser}, {7'd0, want.frame_done});
         end
      end
   end

   // ---------------------------------------------------------------- tests
   // Cleared grid, default size: sand at the top corner drops one row per frame
   task automatic test_reset_defaults();
      read_cell(8'd0, 8'd0);
      write_cell(8'd255, 8'd255, fsgs_pkg::SAND_RESET);
      write_cell(8'd0, 8'd255, 8'hFF);
      advance_frame();
      read_cell(8'd255, 8'd254);
      drain_results();
   endtask

   // Straight down, down-left, down-right at the left edge, blocked at the right edge
   task automatic test_fall_rules();
      write_reg(fsgs_pkg::REG_ACTIVE_WIDTH, 9'd5);
      write_reg(fsgs_pkg::REG_ACTIVE_HEIGHT, 9'd3);
      write_reg(fsgs_pkg::REG_EMPTY_VALUE, 9'd0);
      write_reg(fsgs_pkg::REG_SAND_VALUE, 9'd1);
      write_cell(8'd0, 8'd1, 8'd1);
      write_cell(8'd0, 8'd0, 8'h80);
      write_cell(8'd2, 8'd1, 8'd1);
      write_cell(8'd3, 8'd2, 8'd1);
      write_cell(8'd3, 8'd1, 8'h7E);
      write_cell(8'd3, 8'd0, 8'h55);
      write_cell(8'd4, 8'd1, 8'd1);
      write_cell(8'd4, 8'd0, 8'hAA);
      advance_frame();
      read_cell(8'd1, 8'd0);
      read_cell(8'd2, 8'd0);
      read_cell(8'd2, 8'd1);
      read_cell(8'd4, 8'd1);
      read_cell(8'd3, 8'd2);
      drain_results();
   endtask

   // Out-of-area access, zero sizes, sizes above the grid
   task automatic test_special_sizes();
      write_reg(fsgs_pkg::REG_EMPTY_VALUE, 9'h15A);
      read_cell(8'd5, 8'd0);
      write_cell(8'd6, 8'd0, 8'd3);
      drain_results();
      write_reg(fsgs_pkg::REG_ACTIVE_WIDTH, 9'd0);
      advance_frame();
      drain_results();
      write_reg(fsgs_pkg::REG_ACTIVE_WIDTH, 9'd511);
      write_reg(fsgs_pkg::REG_ACTIVE_HEIGHT, 9'd2);
      advance_frame();
      read_cell(8'd6, 8'd0);
      drain_results();
      write_reg(fsgs_pkg::REG_ACTIVE_WIDTH, 9'd3);
      write_reg(fsgs_pkg::REG_ACTIVE_HEIGHT, 9'd300);
      advance_frame();
      drain_results();
      write_reg(fsgs_pkg::REG_ACTIVE_HEIGHT, 9'd0);
      advance_frame();
      drain_results();
   endtask

   // Sand and empty share one value: moves rewrite the same value
   task automatic test_sand_equals_empty();
      write_reg(fsgs_pkg::REG_ACTIVE_WIDTH, 9'd8);
      write_reg(fsgs_pkg::REG_ACTIVE_HEIGHT, 9'd4);
      write_reg(fsgs_pkg::REG_EMPTY_VALUE, 9'd7);
      write_reg(fsgs_pkg::REG_SAND_VALUE, 9'd7);
      write_cell(8'd1, 8'd2, 8'd7);
      advance_frame();
      read_cell(8'd1, 8'd2);
      drain_results();
   endtask

   // Receiver holds off long enough for the block to stall its input
   task automatic test_backpressure();
      hold_toggle = !hold_toggle;
      read_cell(8'd1, 8'd1);
      send_cell_item(fsgs_pkg::ACT_NONE, 8'hFF, 8'hFF, 8'hFF);
      read_cell(8'd2, 8'd0);
      send_cell_item(fsgs_pkg::ACT_NONE, 8'h00, 8'h00, 8'h00);
      drain_results();
   endtask

   task automatic run_random_phase(bit quiet, logic [8:0] w, logic [8:0] h,
                                   logic [7:0] emp, logic [7:0] snd, int count);
      int         pick;
      int         wc;
      int         hc;
      logic [7:0] c;
      logic [7:0] r;
      logic [7:0] v;
      write_reg(fsgs_pkg::REG_ACTIVE_WIDTH, w);
      write_reg(fsgs_pkg::REG_ACTIVE_HEIGHT, h);
      write_reg(fsgs_pkg::REG_EMPTY_VALUE, {1'b0, emp});
      write_reg(fsgs_pkg::REG_SAND_VALUE, {1'b0, snd});
      no_idle = quiet;
      wc = active_cols();
      hc = active_rows();
      repeat (count) begin
         // mostly inside the active area, sometimes anywhere
         if (wc > 0 && hc > 0 && $urandom_range(99) < 80) begin
            c = 8'($urandom_range(0, wc - 1));
            r = 8'($urandom_range(0, hc - 1));
         end else begin
            c = 8'($urandom_range(0, 255));
            r = 8'($urandom_range(0, 255));
         end
         pick = $urandom_range(99);
         if (pick < 40)
            v = shadow_sand;
         else if (pick < 65)
            v = shadow_empty;
         else
            v = 8'($urandom_range(0, 255));
         pick = $urandom_range(99);
         if (pick < 45)
            write_cell(c, r, v);
         else if (pick < 75)
            read_cell(c, r);
         else if (pick < 90)
            advance_frame();
         else if (pick < 95)
            send_cell_item(fsgs_pkg::ACT_NONE, c, r, v);
         else
            send_cell_item(fsgs_pkg::action_type'($urandom_range(0, 3)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
      end
      drain_results();
      no_idle = 1'b0;
   endtask

   task automatic test_random();
      logic [7:0] e;
      run_random_phase(1'b0, 9'($urandom_range(1, 12)), 9'($urandom_range(1, 12)),
                       8'd0, 8'd1, 14);
      run_random_phase(1'b0, 9'd256, 9'd2, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 14);
      run_random_phase(1'b0, 9'd1, 9'd256, 8'd0, 8'd1, 14);
      run_random_phase(1'b1, 9'($urandom_range(2, 16)), 9'($urandom_range(2, 16)),
                       8'd0, 8'd1, 14);
      e = 8'($urandom_range(0, 255));
      run_random_phase(1'b0, 9'($urandom_range(1, 16)), 9'($urandom_range(1, 16)), e,
                       ($urandom_range(1) != 0) ? e : 8'($urandom_range(0, 255)), 14);
   endtask

   // ---------------------------------------------------------------- sequence
   initial begin
      for (int i = 0; i < GRID_SIDE * GRID_SIDE; i++)
         shadow_grid[i] = 8'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_fall_rules();
      test_special_sizes();
      test_sand_equals_empty();
      test_backpressure();
      test_random();
      drain_results();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && expected_cells.size() == 0)
         $display("falling_sand_grid_step_unit_tb: PASS");
      else
         $display("falling_sand_grid_step_unit_tb: FAIL");
      $finish;
   end

   // Run limit: covers the clearing sweep and a worst-case full-size frame many times over
   initial begin
      #100_000_000;
      $display("falling_sand_grid_step_unit_tb: FAIL");
      $finish;
   end

endmodule
